FILE: hw/rtl/mlfd_pkg.sv
// shared types and constants of the magic/length frame deframer
package mlfd_pkg;

  localparam int unsigned MagicBytes  = 4;
  localparam int unsigned HeaderBytes = 8;
  localparam int unsigned HdrCntW     = $clog2(HeaderBytes);
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [CfgIdxW-1:0] CfgIdxMagic  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxMaxLen = CfgIdxW'(1);

  localparam logic [31:0] MagicReset  = 32'd0;
  localparam logic [31:0] MaxLenReset = 32'd1048576;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_CLOSED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_TOO_LARGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       frame_end;
    status_e    status;
  } res_t;

endpackage

FILE: hw/rtl/mlfd_if.sv
// channel interfaces: byte input, result output, register write
interface mlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mlfd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic       byte_valid;
  logic       frame_end;
  logic [1:0] status;
  modport source (output valid, output body_byte, output byte_valid, output frame_end,
                  output status, input ready);
  modport sink (input valid, input body_byte, input byte_valid, input frame_end,
                input status, output ready);
endinterface

interface mlfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/mlfd_front.sv
// front end: header parsing, checks, body counting and result classification
module mlfd_front import mlfd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  mlfd_byte_if.sink     in_i,
  mlfd_cfg_if.sink      cfg_i,
  input  logic          q_full_i,
  output logic          push_o,
  output res_t          push_res_o
);

  logic [31:0]        magic_word_q, max_len_q;
  phase_e             phase_q, phase_d;
  logic [HdrCntW-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [31:0]        magic_q, magic_d;
  logic [23:0]        len_q, len_d;
  logic [31:0]        rem_q, rem_d;
  logic               accept;
  logic [31:0]        full_len;
  logic [31:0]        rem_dec;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign full_len    = {len_q, in_i.data_byte};
  assign rem_dec     = (rem_q == '0) ? '0 : rem_q - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q <= MagicReset;
      max_len_q    <= MaxLenReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgIdxMagic) magic_word_q <= cfg_i.data;
      else if (cfg_i.index == CfgIdxMaxLen) max_len_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hdr_cnt_q <= '0;
      magic_q   <= '0;
      len_q     <= '0;
      rem_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      magic_q   <= magic_d;
      len_q     <= len_d;
      rem_q     <= rem_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    magic_d    = magic_q;
    len_d      = len_q;
    rem_d      = rem_q;
    push_o     = 1'b0;
    push_res_o = '0;
    unique case (phase_q)
      PH_HEADER: begin
        if (accept) begin
          if (hdr_cnt_q < HdrCntW'(MagicBytes)) begin
            magic_d   = {magic_q[23:0], in_i.data_byte};
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end else if (hdr_cnt_q != HdrCntW'(HeaderBytes - 1)) begin
            len_d     = {len_q[15:0], in_i.data_byte};
            hdr_cnt_d = hdr_cnt_q + 1'b1;
          end else begin
            hdr_cnt_d = '0;
            if (magic_q != magic_word_q) begin
              // bad magic wins over a bad length
              phase_d           = PH_CLOSED;
              push_o            = 1'b1;
              push_res_o.status = STATUS_BAD_MAGIC;
            end else if (full_len > max_len_q) begin
              phase_d           = PH_CLOSED;
              push_o            = 1'b1;
              push_res_o.status = STATUS_TOO_LARGE;
            end else begin
              magic_d = '0;
              len_d   = '0;
              if (full_len == '0) begin
                push_o               = 1'b1;
                push_res_o.frame_end = 1'b1;
              end else begin
                rem_d   = full_len;
                phase_d = PH_BODY;
              end
            end
          end
        end
      end
      PH_BODY: begin
        if (accept) begin
          rem_d                 = rem_dec;
          push_o                = 1'b1;
          push_res_o.body_byte  = in_i.data_byte;
          push_res_o.byte_valid = 1'b1;
          push_res_o.frame_end  = (rem_dec == '0);
          if (rem_dec == '0) phase_d = PH_HEADER;
        end
      end
      default: begin
        // closed: bytes are dropped until reset
      end
    endcase
  end

endmodule

FILE: hw/rtl/mlfd_fifo.sv
// short result queue between front and back
module mlfd_fifo import mlfd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_res_i,
  input  logic pop_i,
  output res_t head_o,
  output logic full_o,
  output logic empty_o
);

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/mlfd_back.sv
// back end: drains the queue into the registered result channel
module mlfd_back import mlfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  res_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  mlfd_res_if.source out_o
);

  res_t out_q;
  logic out_vld_q;

  assign pop_o = !empty_i && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i) begin
    if (pop_o) out_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop_o) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.body_byte  = out_q.body_byte;
  assign out_o.byte_valid = out_q.byte_valid;
  assign out_o.frame_end  = out_q.frame_end;
  assign out_o.status     = out_q.status;

endmodule

FILE: hw/rtl/magic_length_frame_deframer_top.sv
// top level of the magic/length frame deframer
// Takes one received byte per cycle and strips 8-byte headers (big-endian magic word, then
// big-endian body length). Each body byte comes out as one transaction, the last one with
// frame_end; an empty body gives one frame_end transaction with no byte. A wrong magic word
// (status 1) or, failing that, a length above max_body_length (status 2) gives one error
// transaction and closes the stream until reset. A byte is taken every cycle as long as the
// 4-entry result queue has room; results pass through the queue and then the output register.
// Register writes are accepted every cycle and take effect at the next header check;
// indexes 2 and 3 are ignored.
module magic_length_frame_deframer_top import mlfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlfd_byte_if.sink  in_i,
  mlfd_cfg_if.sink   cfg_i,
  mlfd_res_if.source out_o
);

  logic push, pop, q_full, q_empty;
  res_t push_res, head;

  mlfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_res_o (push_res)
  );

  mlfd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_res_i (push_res),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  mlfd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("result pushed into full queue");

  // an error closes the stream, so nothing follows it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_res.status != STATUS_OK) |=> !push)
    else $error("result after stream closed");

  // errors carry no byte and no frame end, body bytes are always ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((push_res.status == STATUS_OK) ||
              (!push_res.byte_valid && !push_res.frame_end)))
    else $error("error result carries byte or frame end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_res.byte_valid) |-> (push_res.status == STATUS_OK))
    else $error("body byte with error status");

endmodule
